[rtl/bdrd_pkg.sv]
// Package for the business-day return date core: channel word types,
// sequencer codes, calendar tables and constant-divide factors.
// No dependencies; imported by rtl/business_day_return_date_core.sv.
`default_nettype none

package bdrd_pkg;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [9:0]  business_days;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  return_day;
    logic [3:0]  return_month;
    logic [13:0] return_year;
    logic [2:0]  return_weekday;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WD_MUL,
    ST_WD_SUM,
    ST_WD_DIV,
    ST_WD_MOD,
    ST_WALK
  } state_t;

  typedef enum logic [1:0] {
    PH_SKIP_START,
    PH_COUNT,
    PH_SKIP_END
  } phase_t;

  // Weekday and month codes
  localparam logic [2:0] WD_SATURDAY = 3'd6;
  localparam logic [2:0] WD_FRIDAY   = 3'd5;
  localparam logic [3:0] MONTH_JAN   = 4'd1;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [3:0] MONTH_DEC   = 4'd12;

  // Reciprocal factors, both taken as product >> RECIP_SHIFT.
  // Exact for x < 43699 (divide by 100) and x < 104857 (divide by 7).
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [16:0] RECIP100    = 17'd5243;
  localparam logic [16:0] RECIP7      = 17'd74899;
  localparam logic [14:0] YEAR_BIAS   = 15'd400;

  // (31 * mm) / 12 term of the weekday formula, indexed by month code
  function automatic logic [5:0] month_offset(input logic [3:0] m);
    logic [5:0] r;
    case (m)
      4'd0:    r = 6'd25;
      4'd1:    r = 6'd28;
      4'd2:    r = 6'd31;
      4'd3:    r = 6'd2;
      4'd4:    r = 6'd5;
      4'd5:    r = 6'd7;
      4'd6:    r = 6'd10;
      4'd7:    r = 6'd12;
      4'd8:    r = 6'd15;
      4'd9:    r = 6'd18;
      4'd10:   r = 6'd20;
      4'd11:   r = 6'd23;
      4'd12:   r = 6'd25;
      4'd13:   r = 6'd28;
      4'd14:   r = 6'd31;
      default: r = 6'd33;
    endcase
    return r;
  endfunction

  // Month length; codes outside January..December count as 31 days
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/business_day_return_date_core.sv]
// Business-day return date core: sequencer, calendar walk and shared
// multiplier for the weekday formula. Depends on rtl/bdrd_pkg.sv.
`default_nettype none
//
// Usage
//   Input channel (in_valid / in_stall / in_data) carries one word with a
//   start date and a count of business days. Output channel (out_valid /
//   out_stall / out_data) returns one word per input: the return date and
//   its weekday (0 Sunday .. 6 Saturday). Friday and Saturday are weekend.
//   in_stall stays high from the accepted word until its result is loaded
//   into the output register; one word is in work at a time.
//   Timing: the walk steps one calendar day per cycle, except while the weekday
//   is rebuilt or the walk holds for the output register. At every month
//   boundary (and once at start) the weekday is rebuilt by a pass through the
//   MUL, SUM, DIV and MOD states and one shared 15x17 multiplier (divide by
//   100, then modulo 7).
//   A finished word sits in the output register while a new input is taken;
//   if the receiver still stalls when the next result is ready, the walk
//   holds until the output register frees up.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending output word.
//
module business_day_return_date_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire bdrd_pkg::in_word_t in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      bdrd_pkg::out_word_t out_data
);
  import bdrd_pkg::*;

  // Control state
  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Walk datapath; the year keeps one extra bit so it can run past the field top
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [14:0] year_r, year_nxt;
  logic [9:0]  left_r, left_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic        leap_r, leap_nxt;

  // Weekday unit
  logic [31:0] prod_r, prod_nxt;
  logic [14:0] sum_r, sum_nxt;
  logic [14:0] mul_a;
  logic [16:0] mul_b;
  logic [31:0] mul_p;

  out_word_t   out_data_r, out_data_nxt;

  // Helper signals
  logic [14:0] year_b;
  logic        early_month;
  logic [7:0]  q100;
  logic [14:0] rem100;
  logic        rem_zero;
  logic [7:0]  q100_yy;
  logic [14:0] year_yy;
  logic [11:0] q7;
  logic [14:0] wd_full;
  logic        weekend;
  logic        bad_month;
  logic        month_end;
  logic        step;
  logic        done;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared multiplier: year / 100 during the first pass, sum / 7 in the second
  always_comb begin
    if (state_r == ST_WD_DIV) begin
      mul_a = sum_r;
      mul_b = RECIP7;
    end else begin
      mul_a = year_b;
      mul_b = RECIP100;
    end
    mul_p = 32'(mul_a) * 32'(mul_b);
  end

  always_comb begin
    // Year biased by 400 keeps every formula term non-negative
    year_b      = year_r + YEAR_BIAS;
    early_month = (month_r <= MONTH_FEB);
    q100        = prod_r[RECIP_SHIFT +: 8];
    rem100      = year_b - ({1'b0, q100, 6'b0} + {2'b0, q100, 5'b0} + {5'b0, q100, 2'b0});
    rem_zero    = (rem100 == 15'd0);
    // January and February count as months of the previous year
    year_yy     = year_b - {14'd0, early_month};
    q100_yy     = q100 - {7'd0, early_month & rem_zero};
    q7          = prod_r[RECIP_SHIFT +: 12];
    wd_full     = sum_r - ({q7, 3'b0} - {3'b0, q7});
    weekend     = (wday_r == WD_FRIDAY) || (wday_r == WD_SATURDAY);
    bad_month   = (month_r == 4'd0) || (month_r > MONTH_DEC);
    month_end   = (day_r >= days_in_month(month_r, leap_r));
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    left_nxt      = left_r;
    wday_nxt      = wday_r;
    leap_nxt      = leap_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    out_data_nxt  = out_data_r;
    step          = 1'b0;
    done          = 1'b0;

    // Drop the output word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          day_nxt   = in_data.start_day;
          month_nxt = in_data.start_month;
          year_nxt  = {1'b0, in_data.start_year};
          left_nxt  = in_data.business_days;
          phase_nxt = PH_SKIP_START;
          state_nxt = ST_WD_MUL;
        end
      end
      ST_WD_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_WD_SUM;
      end
      ST_WD_SUM: begin
        leap_nxt  = rem_zero ? (q100[1:0] == 2'd0) : (year_r[1:0] == 2'd0);
        sum_nxt   = year_yy + {2'b0, year_yy[14:2]} + {9'd0, q100_yy[7:2]}
                    - {7'd0, q100_yy} + {10'd0, day_r} + {9'd0, month_offset(month_r)};
        state_nxt = ST_WD_DIV;
      end
      ST_WD_DIV: begin
        prod_nxt  = mul_p;
        state_nxt = ST_WD_MOD;
      end
      ST_WD_MOD: begin
        wday_nxt  = wd_full[2:0];
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        case (phase_r)
          PH_SKIP_START: begin
            if (weekend) step = 1'b1;
            else         phase_nxt = PH_COUNT;
          end
          PH_COUNT: begin
            if (left_r != 10'd0) begin
              if (!weekend) left_nxt = left_r - 10'd1;
              step = 1'b1;
            end else begin
              phase_nxt = PH_SKIP_END;
            end
          end
          PH_SKIP_END: begin
            if (weekend) step = 1'b1;
            else         done = 1'b1;
          end
          default: phase_nxt = PH_SKIP_START;
        endcase

        if (step) begin
          if (month_end) begin
            // Roll to the first of the next month and rebuild the weekday
            day_nxt = 5'd1;
            if ((month_r == MONTH_DEC) || bad_month) begin
              month_nxt = MONTH_JAN;
              year_nxt  = year_r + 15'd1;
            end else begin
              month_nxt = month_r + 4'd1;
            end
            state_nxt = ST_WD_MUL;
          end else begin
            day_nxt  = day_r + 5'd1;
            wday_nxt = (wday_r == WD_SATURDAY) ? 3'd0 : wday_r + 3'd1;
          end
        end

        // Hold the finished word until the output register is free
        if (done && (!out_valid_r || !out_stall)) begin
          out_data_nxt.return_day     = day_r;
          out_data_nxt.return_month   = month_r;
          out_data_nxt.return_year    = year_r[13:0];
          out_data_nxt.return_weekday = wday_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_SKIP_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r      <= day_nxt;
    month_r    <= month_nxt;
    year_r     <= year_nxt;
    left_r     <= left_nxt;
    wday_r     <= wday_nxt;
    leap_r     <= leap_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[bench/business_day_return_date_core_test.sv]
`timescale 1ns / 100ps
// Testbench for business_day_return_date_core: a directed table, then random start dates;
// every return date is checked against a calendar-walk predictor kept here or a date given by hand in the table.
// Depends on rtl/bdrd_pkg.sv (word types, month and weekday codes) and the core itself.
module business_day_return_date_core_test;
  import bdrd_pkg::*;

  localparam int unsigned N_DIRECTED     = 22;
  localparam int unsigned N_RANDOM       = 390;
  localparam int unsigned MAX_GAP        = 18;
  // Receiver hold-off long enough for the core to finish a word, park it in the
  // output register, finish the next one and then stall its input.
  localparam int unsigned LONG_HOLD      = 4000;
  localparam int unsigned HOLD_AT_RESULT = 60;
  localparam int unsigned PAUSE_AT_ITEM  = 200;
  // Allow well past the time a word with no walk takes, for a stray word.
  localparam int unsigned SETTLE_CYCLES  = 50;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned LONG_WALK_DAYS = 512;

  // Weekday codes not given by the package (Friday and Saturday are).
  localparam logic [2:0] WD_SUNDAY  = 3'd0;
  localparam logic [2:0] WD_MONDAY  = 3'd1;
  localparam logic [2:0] WD_TUESDAY = 3'd2;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // One row of the directed table. Where has_exp is low the predictor supplies
  // the expected date; where it is high the date below is obvious by hand.
  typedef struct packed {
    in_word_t  stim;
    logic      has_exp;
    out_word_t exp;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Monday with no business days: the same date back
    '{'{5'd1, MONTH_JAN, 14'd2024, 10'd0}, 1'b1, '{5'd1, MONTH_JAN, 14'd2024, WD_MONDAY}},
    // Sunday with no business days: the same date back
    '{'{5'd31, MONTH_DEC, 14'd2023, 10'd0}, 1'b1, '{5'd31, MONTH_DEC, 14'd2023, WD_SUNDAY}},
    // Friday start: skip the weekend to Sunday
    '{'{5'd5, MONTH_JAN, 14'd2024, 10'd0}, 1'b1, '{5'd7, MONTH_JAN, 14'd2024, WD_SUNDAY}},
    // Saturday start: skip to Sunday
    '{'{5'd6, MONTH_JAN, 14'd2024, 10'd0}, 1'b1, '{5'd7, MONTH_JAN, 14'd2024, WD_SUNDAY}},
    // One day from Monday lands on Tuesday
    '{'{5'd1, MONTH_JAN, 14'd2024, 10'd1}, 1'b1, '{5'd2, MONTH_JAN, 14'd2024, WD_TUESDAY}},
    // One day from Thursday lands on Friday, then skips to Sunday
    '{'{5'd4, MONTH_JAN, 14'd2024, 10'd1}, 1'b1, '{5'd7, MONTH_JAN, 14'd2024, WD_SUNDAY}},
    // February ends: leap year, common year, century rule, 400-year rule
    '{'{5'd28, MONTH_FEB, 14'd2024, 10'd5}, 1'b0, '0},
    '{'{5'd28, MONTH_FEB, 14'd2023, 10'd5}, 1'b0, '0},
    '{'{5'd28, MONTH_FEB, 14'd2100, 10'd3}, 1'b0, '0},
    '{'{5'd28, MONTH_FEB, 14'd2000, 10'd3}, 1'b0, '0},
    // Largest calendar year with the longest walk
    '{'{5'd31, MONTH_DEC, 14'd9999, 10'd1023}, 1'b0, '0},
    // Smallest date, and year zero
    '{'{5'd1, MONTH_JAN, 14'd1, 10'd0}, 1'b0, '0},
    '{'{5'd1, MONTH_JAN, 14'd0, 10'd10}, 1'b0, '0},
    // Top of the year field with the longest walk: the year wraps
    '{'{5'd31, MONTH_DEC, 14'd16383, 10'd1023}, 1'b0, '0},
    // Month codes outside January..December
    '{'{5'd15, 4'd0, 14'd2024, 10'd20}, 1'b0, '0},
    '{'{5'd31, 4'd13, 14'd2024, 10'd3}, 1'b0, '0},
    '{'{5'd31, 4'd14, 14'd2024, 10'd3}, 1'b0, '0},
    '{'{5'd31, 4'd15, 14'd2024, 10'd3}, 1'b0, '0},
    // Day zero, and days past the end of their month
    '{'{5'd0, 4'd3, 14'd2024, 10'd2}, 1'b0, '0},
    '{'{5'd31, MONTH_FEB, 14'd2023, 10'd2}, 1'b0, '0},
    '{'{5'd31, 4'd4, 14'd2024, 10'd4}, 1'b0, '0},
    // Only the top bit of the day count
    '{'{5'd15, 4'd6, 14'd2024, 10'd512}, 1'b0, '0}
  };

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // Return dates still owed by the core, oldest first.
  out_word_t   pending_returns [$];
  int unsigned words_sent      = 0;
  int unsigned dates_seen      = 0;
  int unsigned date_mismatches = 0;
  int unsigned long_walks      = 0;
  int unsigned odd_dates       = 0;

  business_day_return_date_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Gregorian rule: every 400th year, or every 4th that is not a century.
  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
  endfunction

  // Month codes outside January..December count as 31-day months.
  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    if (m < MONTH_JAN || m > MONTH_DEC) return 31;
    if (m == MONTH_FEB) return leap_year(y) ? 29 : 28;
    return MONTH_DAYS[m - 1];
  endfunction

  // Mod-7 weekday, 0 = Sunday. January and February count as months 11 and 12
  // of the year before; 400 years are added so no term goes negative.
  function automatic logic [2:0] weekday_of_date(input int unsigned y, input int unsigned m,
                                                 input int unsigned d);
    int unsigned early;
    int unsigned yy;
    int unsigned mm;
    early = (m <= MONTH_FEB) ? 1 : 0;
    yy    = y + 400 - early;
    mm    = m + 12 * early - 2;
    return 3'((d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7);
  endfunction

  function automatic bit weekend_day(input int unsigned y, input int unsigned m,
                                     input int unsigned d);
    logic [2:0] wd;
    wd = weekday_of_date(y, m, d);
    return wd == WD_FRIDAY || wd == WD_SATURDAY;
  endfunction

  // Step one calendar day. A bad month code rolls over into January of the
  // next year; the year is kept wide so it can pass the field's top.
  function automatic void advance_day(inout int unsigned y, inout int unsigned m,
                                      inout int unsigned d);
    if (d >= month_length(y, m)) begin
      d = 1;
      if (m == MONTH_DEC || m < MONTH_JAN || m > MONTH_DEC) begin
        m = MONTH_JAN;
        y = y + 1;
      end else begin
        m = m + 1;
      end
    end else begin
      d = d + 1;
    end
  endfunction

  // Skip a weekend at the start, burn business days one calendar day at a time,
  // then skip any weekend the walk ends on.
  function automatic out_word_t return_date_of(input in_word_t w);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned left;
    out_word_t   r;
    d    = w.start_day;
    m    = w.start_month;
    y    = w.start_year;
    left = w.business_days;
    while (weekend_day(y, m, d)) advance_day(y, m, d);
    while (left > 0) begin
      if (!weekend_day(y, m, d)) left--;
      advance_day(y, m, d);
    end
    while (weekend_day(y, m, d)) advance_day(y, m, d);
    r.return_day     = d[4:0];
    r.return_month   = m[3:0];
    r.return_year    = y[13:0];
    r.return_weekday = weekday_of_date(y, m, d);
    return r;
  endfunction

  // Mostly real dates with a short count; some century years; a tenth pure
  // noise over every field bit. Long counts are kept rare to bound the run.
  function automatic in_word_t random_trip();
    in_word_t    w;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      w.start_day   = 5'($urandom);
      w.start_month = 4'($urandom);
      w.start_year  = 14'($urandom);
    end else begin
      w.start_month = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
      if (pick < 20) w.start_year = 14'($urandom_range(0, 99) * 100);
      else           w.start_year = 14'($urandom_range(1, 9999));
      w.start_day = 5'($urandom_range(1, month_length(w.start_year, w.start_month)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 65)      span = $urandom_range(0, 30);
    else if (pick < 88) span = $urandom_range(31, 250);
    else if (pick < 97) span = $urandom_range(0, 1023);
    else                span = 1023;
    w.business_days = 10'(span);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word after a random gap and hold it until the core takes it.
  // Every 64 words, the first 16 go back to back.
  task automatic offer_word(input in_word_t w, input out_word_t expected_date);
    int unsigned gap;
    gap = (words_sent % 64 < 16) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_returns.push_back(expected_date);
    words_sent++;
    if (w.business_days >= LONG_WALK_DAYS) long_walks++;
    if (w.start_day == 0 || w.start_day > month_length(w.start_year, w.start_month) ||
        w.start_month < MONTH_JAN || w.start_month > MONTH_DEC) odd_dates++;
  endtask

  // Drop valid and hold off until every owed date has come back.
  task automatic wait_for_returns();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_returns.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t  w;
    stim_row_t row;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      offer_word(row.stim, row.has_exp ? row.exp : return_date_of(row.stim));
    end
    wait_for_returns();

    for (int i = 0; i < N_RANDOM; i++) begin
      // Pause once mid-run so the core drains completely with the sender idle.
      if (i == PAUSE_AT_ITEM) wait_for_returns();
      w = random_trip();
      offer_word(w, return_date_of(w));
    end

    // Wait out the last dates, then give a stray word time to show up.
    wait_for_returns();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d from the table): %0d walks of %0d+ business days,",
             words_sent, N_DIRECTED, long_walks, LONG_WALK_DAYS);
    $display("%0d starts off the calendar.", odd_dates);
    $display("Received %0d return dates, %0d wrong or unexpected.", dates_seen, date_mismatches);
    if (date_mismatches == 0) begin
      $display("PASS business_day_return_date_core");
    end else begin
      $display("FAIL business_day_return_date_core");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Draw a stall before each date; one long hold-off lets the core fill up while
  // the sender keeps offering. Every 64 dates, 16 are taken without stalling.
  initial begin
    int unsigned hold;
    out_word_t   want;
    while (!rst_n) @(posedge clk);
    forever begin
      if (dates_seen == HOLD_AT_RESULT)   hold = LONG_HOLD;
      else if (dates_seen % 64 >= 32 && dates_seen % 64 < 48) hold = 0;
      else                                hold = $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);

      // A word moved at this edge: compare it with the oldest owed date.
      dates_seen++;
      if (pending_returns.size() == 0) begin
        date_mismatches++;
        if (date_mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected word: day %0d month %0d year %0d weekday %0d", $realtime,
                   out_data.return_day, out_data.return_month, out_data.return_year,
                   out_data.return_weekday);
      end else begin
        want = pending_returns.pop_front();
        if (out_data.return_day !== want.return_day ||
            out_data.return_month !== want.return_month ||
            out_data.return_year !== want.return_year ||
            out_data.return_weekday !== want.return_weekday) begin
          date_mismatches++;
          if (date_mismatches <= REPORT_LIMIT)
            $display("[%0t] date %0d: want %0d-%0d-%0d wd %0d, got %0d-%0d-%0d wd %0d",
                     $realtime, dates_seen, want.return_year, want.return_month,
                     want.return_day, want.return_weekday, out_data.return_year,
                     out_data.return_month, out_data.return_day, out_data.return_weekday);
        end
      end
    end
  end

  // Hang guard: several times the slowest correct run (every word a full walk).
  initial begin
    #30_000_000;
    $display("FAIL business_day_return_date_core");
    $finish;
  end

endmodule

[sim.f]
rtl/bdrd_pkg.sv
rtl/business_day_return_date_core.sv
bench/business_day_return_date_core_test.sv
